@@ sv/pwm_smooth_ramp_top_assert.svh @@
// assertion macros for the ramp block
`ifndef PWM_SMOOTH_RAMP_TOP_ASSERT_SVH
`define PWM_SMOOTH_RAMP_TOP_ASSERT_SVH

// same-cycle implication
`define PWMSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PWMSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pwmsr_pkg.sv @@
package pwmsr_pkg;

  localparam int LEVEL_W = 16;
  localparam int STEP_W  = 8;
  localparam int TICK_W  = 8;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = LEVEL_W + STEP_W;
  localparam int INTV_W  = 32;
  localparam int CNT_W   = 5;
  localparam int PC_W    = 4;

  localparam logic [IDX_W-1:0] REG_LEVEL_LIMIT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_DELTA    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RAMP_TIME_MS = 3'd3;
  localparam logic [IDX_W-1:0] REG_TICKS_PER_MS = 3'd4;

  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_CAPTURE = 4'd1;
  localparam logic [3:0] OP_DIST    = 4'd2;
  localparam logic [3:0] OP_LATCH   = 4'd3;
  localparam logic [3:0] OP_MUL1    = 4'd4;
  localparam logic [3:0] OP_DIVSTEP = 4'd5;
  localparam logic [3:0] OP_MUL2    = 4'd6;
  localparam logic [3:0] OP_ELAPSED = 4'd7;
  localparam logic [3:0] OP_STEP    = 4'd8;
  localparam logic [3:0] OP_FINISH  = 4'd9;
  localparam logic [3:0] OP_SNAP    = 4'd10;
  localparam logic [3:0] OP_CLEAR   = 4'd11;
  localparam logic [3:0] OP_OUT     = 4'd12;

  localparam logic [2:0] CND_NONE      = 3'd0;
  localparam logic [2:0] CND_ALWAYS    = 3'd1;
  localparam logic [2:0] CND_NO_IN     = 3'd2;
  localparam logic [2:0] CND_NO_SMOOTH = 3'd3;
  localparam logic [2:0] CND_BELOW_MIN = 3'd4;
  localparam logic [2:0] CND_CNT_NZ    = 3'd5;
  localparam logic [2:0] CND_NOT_DUE   = 3'd6;
  localparam logic [2:0] CND_OUT_BUSY  = 3'd7;

  localparam logic [PC_W-1:0] PC_START = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd5;
  localparam logic [PC_W-1:0] PC_SNAP  = 4'd11;
  localparam logic [PC_W-1:0] PC_CLEAR = 4'd12;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd13;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic no_smooth;
    logic below_min;
    logic cnt_nz;
    logic not_due;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] addr);
    ctrl_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: PC_START};
    unique case (addr)
      4'd0:  w = '{op: OP_CAPTURE, cond: CND_NO_IN,     target: PC_START};
      4'd1:  w = '{op: OP_DIST,    cond: CND_NO_SMOOTH, target: PC_SNAP};
      4'd2:  w = '{op: OP_NOP,     cond: CND_BELOW_MIN, target: PC_CLEAR};
      4'd3:  w = '{op: OP_LATCH,   cond: CND_NONE,      target: PC_START};
      4'd4:  w = '{op: OP_MUL1,    cond: CND_NONE,      target: PC_START};
      4'd5:  w = '{op: OP_DIVSTEP, cond: CND_CNT_NZ,    target: PC_DIV};
      4'd6:  w = '{op: OP_MUL2,    cond: CND_NONE,      target: PC_START};
      4'd7:  w = '{op: OP_ELAPSED, cond: CND_NONE,      target: PC_START};
      4'd8:  w = '{op: OP_NOP,     cond: CND_NOT_DUE,   target: PC_OUT};
      4'd9:  w = '{op: OP_STEP,    cond: CND_NONE,      target: PC_START};
      4'd10: w = '{op: OP_FINISH,  cond: CND_ALWAYS,    target: PC_OUT};
      4'd11: w = '{op: OP_SNAP,    cond: CND_ALWAYS,    target: PC_OUT};
      4'd12: w = '{op: OP_CLEAR,   cond: CND_NONE,      target: PC_START};
      4'd13: w = '{op: OP_OUT,     cond: CND_OUT_BUSY,  target: PC_OUT};
      4'd14: w = '{op: OP_NOP,     cond: CND_ALWAYS,    target: PC_START};
      default: w = '{op: OP_NOP,   cond: CND_ALWAYS,    target: PC_START};
    endcase
    return w;
  endfunction

endpackage

@@ sv/pwmsr_useq.sv @@
module pwmsr_useq (
  input  logic                          clk,
  input  logic                          rst,
  input  pwmsr_pkg::stat_t              stat,
  output pwmsr_pkg::ctrl_t              ctrl,
  output logic [pwmsr_pkg::PC_W-1:0]    pc
);

  logic [pwmsr_pkg::PC_W-1:0] pc_next;
  logic                       take;

  assign ctrl = pwmsr_pkg::ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      pwmsr_pkg::CND_NONE:      take = 1'b0;
      pwmsr_pkg::CND_ALWAYS:    take = 1'b1;
      pwmsr_pkg::CND_NO_IN:     take = stat.no_in;
      pwmsr_pkg::CND_NO_SMOOTH: take = stat.no_smooth;
      pwmsr_pkg::CND_BELOW_MIN: take = stat.below_min;
      pwmsr_pkg::CND_CNT_NZ:    take = stat.cnt_nz;
      pwmsr_pkg::CND_NOT_DUE:   take = stat.not_due;
      pwmsr_pkg::CND_OUT_BUSY:  take = stat.out_busy;
      default:                  take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pwmsr_pkg::PC_START;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ sv/pwmsr_dp.sv @@
module pwmsr_dp #(
  parameter int TIMER_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pwmsr_pkg::ctrl_t                    ctrl,
  output pwmsr_pkg::stat_t                    stat,
  input  logic                                cfg_we,
  input  logic [pwmsr_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pwmsr_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pwmsr_pkg::LEVEL_W-1:0]       target_level,
  input  logic [TIMER_BITS-1:0]               timer_now,
  input  logic                                arm_ramp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pwmsr_pkg::LEVEL_W-1:0]       level_out,
  output logic                                ramp_active
);

  localparam int LW = pwmsr_pkg::LEVEL_W;
  localparam int SW = pwmsr_pkg::STEP_W;
  localparam int PW = pwmsr_pkg::PROD_W;
  localparam int IW = pwmsr_pkg::INTV_W;
  localparam int CW = pwmsr_pkg::CNT_W;

  logic [LW-1:0]         level_limit;
  logic [SW-1:0]         step_size;
  logic [LW-1:0]         min_delta;
  logic [LW-1:0]         ramp_time_ms;
  logic [pwmsr_pkg::TICK_W-1:0] ticks_per_ms;

  logic [LW-1:0]         level;
  logic [LW-1:0]         latched_distance;
  logic                  smoothing;
  logic [TIMER_BITS-1:0] last_step_time;

  logic [LW-1:0]         tgt;
  logic [TIMER_BITS-1:0] now_r;
  logic [LW-1:0]         distance;
  logic [PW-1:0]         quo;
  logic [LW-1:0]         rem;
  logic [CW-1:0]         cnt;
  logic [IW-1:0]         intv;
  logic                  due;

  logic                  out_busy;
  logic                  in_beat;
  logic [LW:0]           div_sh;
  logic                  div_ge;
  logic [LW:0]           div_diff;
  logic [LW-1:0]         tgt_clamp;
  logic [TIMER_BITS-1:0] elapsed;
  logic [LW:0]           lvl_up;
  logic [LW-1:0]         lvl_step;

  assign out_busy = out_valid && out_stall;
  assign in_stall = (ctrl.op != pwmsr_pkg::OP_CAPTURE);
  assign in_beat  = in_valid && !in_stall;

  assign stat.no_in     = !in_valid;
  assign stat.no_smooth = !smoothing;
  assign stat.below_min = (distance < min_delta);
  assign stat.cnt_nz    = (cnt != '0);
  assign stat.not_due   = !due;
  assign stat.out_busy  = out_busy;

  assign tgt_clamp = (target_level > level_limit) ? level_limit : target_level;
  assign div_sh    = {rem, quo[PW-1]};
  assign div_ge    = (div_sh >= {1'b0, latched_distance});
  assign div_diff  = div_sh - {1'b0, latched_distance};
  assign elapsed   = now_r - last_step_time;
  assign lvl_up    = {1'b0, level} + (LW + 1)'(step_size);

  always_comb begin
    if (latched_distance > LW'(step_size)) begin
      if (level < tgt) begin
        lvl_step = (lvl_up > {1'b0, level_limit}) ? level_limit : lvl_up[LW-1:0];
      end else begin
        lvl_step = (level > LW'(step_size)) ? level - LW'(step_size) : '0;
      end
    end else begin
      lvl_step = tgt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      level_limit  <= 16'd255;
      step_size    <= 8'd1;
      min_delta    <= 16'd1;
      ramp_time_ms <= 16'd1000;
      ticks_per_ms <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwmsr_pkg::REG_LEVEL_LIMIT:  level_limit  <= cfg_data;
        pwmsr_pkg::REG_STEP_SIZE:    step_size    <= cfg_data[SW-1:0];
        pwmsr_pkg::REG_MIN_DELTA:    min_delta    <= cfg_data;
        pwmsr_pkg::REG_RAMP_TIME_MS: ramp_time_ms <= cfg_data;
        pwmsr_pkg::REG_TICKS_PER_MS: ticks_per_ms <= cfg_data[pwmsr_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // ramp state and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      level            <= '0;
      latched_distance <= '0;
      smoothing        <= 1'b0;
      last_step_time   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && ctrl.op != pwmsr_pkg::OP_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        pwmsr_pkg::OP_CAPTURE: begin
          if (in_beat && arm_ramp) begin
            smoothing <= 1'b1;
          end
        end
        pwmsr_pkg::OP_LATCH: begin
          if (latched_distance == '0) begin
            latched_distance <= distance;
          end
        end
        pwmsr_pkg::OP_STEP: level <= lvl_step;
        pwmsr_pkg::OP_FINISH: begin
          if (level == tgt) begin
            latched_distance <= '0;
            smoothing        <= 1'b0;
          end else begin
            smoothing <= 1'b1;
          end
          last_step_time <= now_r;
        end
        pwmsr_pkg::OP_SNAP: level <= tgt;
        pwmsr_pkg::OP_CLEAR: begin
          latched_distance <= '0;
          smoothing        <= 1'b0;
        end
        pwmsr_pkg::OP_OUT: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      pwmsr_pkg::OP_CAPTURE: begin
        if (in_beat) begin
          tgt   <= tgt_clamp;
          now_r <= timer_now;
        end
      end
      pwmsr_pkg::OP_DIST: distance <= (level > tgt) ? level - tgt : tgt - level;
      pwmsr_pkg::OP_MUL1: begin
        quo <= PW'(ramp_time_ms) * PW'(step_size);
        rem <= '0;
        cnt <= CW'(PW - 1);
      end
      pwmsr_pkg::OP_DIVSTEP: begin
        quo <= {quo[PW-2:0], div_ge};
        rem <= div_ge ? div_diff[LW-1:0] : div_sh[LW-1:0];
        cnt <= cnt - 1'b1;
      end
      pwmsr_pkg::OP_MUL2: begin
        // zero latched distance means no wait
        intv <= (latched_distance == '0) ? '0 : IW'(quo) * IW'(ticks_per_ms);
      end
      pwmsr_pkg::OP_ELAPSED: due <= (IW'(elapsed) >= intv);
      pwmsr_pkg::OP_OUT: begin
        if (!out_busy) begin
          level_out   <= level;
          ramp_active <= smoothing;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/pwm_smooth_ramp_top.sv @@
// channel | handshake           | payload
// cfg     | cfg_we              | cfg_index, cfg_data
// in      | in_valid / in_stall | target_level, timer_now, arm_ramp
// out     | out_valid/out_stall | level_out, ramp_active
//
// without smoothing a poll snaps the level to the target; with a ramp it makes a step check
// the ramp step check runs the 24-iteration restoring divide loop in the microprogram
// one poll at a time; the next poll is taken once the result sits in the output register
// an output stall holds the sequencer at its output step until the beat leaves
// synchronous reset puts the sequencer at step 0 and loads the register defaults
`include "pwm_smooth_ramp_top_assert.svh"

module pwm_smooth_ramp_top #(
  parameter int TIMER_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pwmsr_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pwmsr_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pwmsr_pkg::LEVEL_W-1:0]       target_level,
  input  logic [TIMER_BITS-1:0]               timer_now,
  input  logic                                arm_ramp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pwmsr_pkg::LEVEL_W-1:0]       level_out,
  output logic                                ramp_active
);

  pwmsr_pkg::ctrl_t             ctrl;
  pwmsr_pkg::stat_t             stat;
  logic [pwmsr_pkg::PC_W-1:0]   pc;
  logic                         at_start;
  logic                         out_step;

  assign at_start = (pc == pwmsr_pkg::PC_START);
  assign out_step = (ctrl.op == pwmsr_pkg::OP_OUT);

  pwmsr_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .pc   (pc)
  );

  pwmsr_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .target_level (target_level),
    .timer_now    (timer_now),
    .arm_ramp     (arm_ramp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_out    (level_out),
    .ramp_active  (ramp_active)
  );

  `PWMSR_ASSERT_NOW(a_take_at_start, !in_stall, at_start, "input open away from step 0")
  `PWMSR_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second poll taken")
  `PWMSR_ASSERT_NOW(a_out_from_ucode, $rose(out_valid), $past(out_step), "beat without out step")

endmodule
